// ----- design/sll_pkg.sv -----
// ----------------------------------------------------------------------------
// sll_pkg
// Shared widths, operation codes and status codes for the linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

    localparam int SLOTS_DEFAULT = 128;

    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int LEN_OUT_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- design/static_linked_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// static_linked_list_engine_core
// Cursor-linked list in a slot RAM with a free chain, insert and delete by
// 1-based position.
// ----------------------------------------------------------------------------
// One operation at a time. For a valid insert or delete the sequencer follows
// one link per cycle through the single read port of the link RAM, then
// splices or unlinks through its single write port in the B, C and D states.
// A request with a bad position or an insert into a full list skips the walk
// and goes straight to the result state. After reset a clearing pass over
// every slot builds the free chain in the link RAM; no input is taken until
// it ends. The result register lets the next input be taken while a result
// waits on the output.
module static_linked_list_engine_core #(
    parameter int SLOTS = sll_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position[6:0], insert_value[38:7], zero[39]
    input  logic [0:0]  i_s_axis_tuser,   // op[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // removed_value[31:0], length[38:32], zero[39]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = ((AW > sll_pkg::POS_W) ? AW : sll_pkg::POS_W) + 1;
    localparam logic [AW-1:0] HEADER = AW'(SLOTS - 1);
    localparam logic [AW-1:0] LAST_ELEM = AW'(SLOTS - 3);
    localparam logic [AW-1:0] FULL_LEN = AW'(SLOTS - 2);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_INS_B = 4'd3;
    localparam logic [3:0] S_INS_C = 4'd4;
    localparam logic [3:0] S_INS_D = 4'd5;
    localparam logic [3:0] S_DEL_B = 4'd6;
    localparam logic [3:0] S_DEL_C = 4'd7;
    localparam logic [3:0] S_DEL_D = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // control state
    logic [3:0]                      r_state, n_state;
    logic [AW-1:0]                   r_init_cnt, n_init_cnt;
    logic [AW-1:0]                   r_fh, n_fh;
    logic [AW-1:0]                   r_len, n_len;
    logic                            r_out_valid, n_out_valid;

    // payload
    logic                            r_op, n_op;
    logic [sll_pkg::VAL_W-1:0]       r_val, n_val;
    logic [sll_pkg::POS_W-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]                   r_cur, n_cur;
    logic                            r_use_rd, n_use_rd;
    logic [AW-1:0]                   r_pred, n_pred;
    logic [AW-1:0]                   r_nxt, n_nxt;
    logic [AW-1:0]                   r_slot, n_slot;
    logic [sll_pkg::ST_W-1:0]        r_status, n_status;
    logic [sll_pkg::VAL_W-1:0]       r_removed, n_removed;
    logic [sll_pkg::ST_W-1:0]        r_out_status, n_out_status;
    logic [sll_pkg::VAL_W-1:0]       r_out_removed, n_out_removed;
    logic [sll_pkg::LEN_OUT_W-1:0]   r_out_len, n_out_len;

    // RAM ports
    logic                            link_we;
    logic [AW-1:0]                   link_waddr;
    logic [AW-1:0]                   link_wdata;
    logic [AW-1:0]                   raddr;
    logic [AW-1:0]                   link_rd;
    logic                            val_we;
    logic [sll_pkg::VAL_W-1:0]       val_rd;

    logic [sll_pkg::POS_W-1:0]       in_pos;
    logic                            in_op;
    logic [CW-1:0]                   pos_ext;
    logic [CW-1:0]                   len_ext;
    logic [AW-1:0]                   cur;
    logic                            in_xfer;

    assign in_pos  = i_s_axis_tdata[sll_pkg::POS_W-1:0];
    assign in_op   = i_s_axis_tuser[0];
    assign pos_ext = CW'(in_pos);
    assign len_ext = CW'(r_len);
    assign cur     = r_use_rd ? link_rd : r_cur;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    sll_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rd)
    );

    sll_ram #(
        .WIDTH (sll_pkg::VAL_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_slot),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (val_rd)
    );

    always_comb begin
        n_state       = r_state;
        n_init_cnt    = r_init_cnt;
        n_fh          = r_fh;
        n_len         = r_len;
        n_out_valid   = r_out_valid;
        n_op          = r_op;
        n_val         = r_val;
        n_cnt         = r_cnt;
        n_cur         = r_cur;
        n_use_rd      = r_use_rd;
        n_pred        = r_pred;
        n_nxt         = r_nxt;
        n_slot        = r_slot;
        n_status      = r_status;
        n_removed     = r_removed;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_len     = r_out_len;
        link_we       = 1'b0;
        link_waddr    = r_pred;
        link_wdata    = r_slot;
        val_we        = 1'b0;
        raddr         = cur;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                link_we    = 1'b1;
                link_waddr = r_init_cnt;
                link_wdata = (r_init_cnt != '0 && r_init_cnt <= LAST_ELEM) ?
                             r_init_cnt + AW'(1) : '0;
                n_init_cnt = r_init_cnt + AW'(1);
                if (r_init_cnt == HEADER) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_op      = in_op;
                    n_val     = i_s_axis_tdata[sll_pkg::POS_W +: sll_pkg::VAL_W];
                    n_cnt     = in_pos - sll_pkg::POS_W'(1);
                    n_cur     = HEADER;
                    n_use_rd  = 1'b0;
                    n_removed = '0;
                    n_status  = sll_pkg::ST_OK;
                    n_state   = S_WALK;
                    if (in_op == sll_pkg::OP_INSERT) begin
                        if (in_pos == '0 || pos_ext > len_ext + CW'(1)) begin
                            n_status = sll_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end else if (r_fh == '0) begin
                            n_status = sll_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end
                    end else begin
                        if (in_pos == '0 || pos_ext > len_ext) begin
                            n_status = sll_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_WALK: begin
                raddr = cur;
                if (r_cnt == '0) begin
                    n_pred  = cur;
                    n_state = (r_op == sll_pkg::OP_INSERT) ? S_INS_B : S_DEL_B;
                end else begin
                    n_use_rd = 1'b1;
                    n_cnt    = r_cnt - sll_pkg::POS_W'(1);
                end
            end
            S_INS_B: begin
                n_nxt   = link_rd;
                n_slot  = r_fh;
                raddr   = r_fh;
                n_state = S_INS_C;
            end
            S_INS_C: begin
                n_fh       = link_rd;
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = r_nxt;
                val_we     = 1'b1;
                n_state    = S_INS_D;
            end
            S_INS_D: begin
                link_we    = 1'b1;
                link_waddr = r_pred;
                link_wdata = r_slot;
                n_len      = r_len + AW'(1);
                n_state    = S_DONE;
            end
            S_DEL_B: begin
                n_slot  = link_rd;
                raddr   = link_rd;
                n_state = S_DEL_C;
            end
            S_DEL_C: begin
                link_we    = 1'b1;
                link_waddr = r_pred;
                link_wdata = link_rd;
                n_removed  = val_rd;
                n_state    = S_DEL_D;
            end
            S_DEL_D: begin
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = r_fh;
                n_fh       = r_slot;
                n_len      = r_len - AW'(1);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_removed = r_removed;
                    n_out_len     = sll_pkg::LEN_OUT_W'(r_len);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_fh        <= AW'(1);
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_fh        <= n_fh;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_val         <= n_val;
        r_cnt         <= n_cnt;
        r_cur         <= n_cur;
        r_use_rd      <= n_use_rd;
        r_pred        <= n_pred;
        r_nxt         <= n_nxt;
        r_slot        <= n_slot;
        r_status      <= n_status;
        r_removed     <= n_removed;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_len     <= n_out_len;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {1'b0, r_out_len, r_out_removed};

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= FULL_LEN)
        else $error("list length above slot capacity");

    a_free_empty_iff_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_fh == '0) == (r_len == FULL_LEN)))
        else $error("free chain and length disagree");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == sll_pkg::ST_FULL) |-> (r_fh == '0))
        else $error("list full reported with free slots left");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> (!link_we && !val_we))
        else $error("RAM written outside an operation");
`endif

endmodule

// ----- design/sll_ram.sv -----
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/static_linked_list_engine_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine_core_test
// Self-checking bench for the slot-array linked list engine. A mirror of the
// list, its links and its free chain predicts status, removed value and length
// for every request taken on the input stream. Each transfer on the output
// stream is compared with the oldest prediction. Random traffic fills the list
// to full and drains it to empty again, under changing backpressure.
// ----------------------------------------------------------------------------
module static_linked_list_engine_core_test;

    localparam int SLOTS      = sll_pkg::SLOTS_DEFAULT;
    localparam int LINK_W     = $clog2(SLOTS);
    localparam int HDR_SLOT   = SLOTS - 1;
    localparam int MAX_LEN    = SLOTS - 2;
    localparam int RAND_ITEMS = 410;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 20000;

    typedef struct packed {
        logic [sll_pkg::ST_W-1:0]      status;
        logic [sll_pkg::VAL_W-1:0]     removed;
        logic [sll_pkg::LEN_OUT_W-1:0] length;
    } t_list_reply;

    class t_list_mirror;
        logic [sll_pkg::VAL_W-1:0] slot_data [SLOTS];
        logic [LINK_W-1:0]         slot_next [SLOTS];
        logic [LINK_W-1:0]         free_slot;
        int                        elems;
        t_list_reply               awaited[$];
        int                        mismatches;
        int                        replies;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_data[i] = '0;
                slot_next[i] = '0;
            end
            for (int i = 1; i < SLOTS - 2; i++) slot_next[i] = LINK_W'(i + 1);
            free_slot  = LINK_W'(1);
            elems      = 0;
            mismatches = 0;
            replies    = 0;
        endfunction

        // walk from the header to the slot ahead of position pos
        function int pred_of(int pos);
            int j;
            j = HDR_SLOT;
            for (int c = 1; c < pos; c++) j = slot_next[j];
            return j;
        endfunction

        function void take_request(logic op, logic [sll_pkg::POS_W-1:0] pos,
                                   logic [sll_pkg::VAL_W-1:0] val);
            t_list_reply r;
            int          pred;
            int          s;
            r.status  = sll_pkg::ST_OK;
            r.removed = '0;
            if (op == sll_pkg::OP_INSERT) begin
                if (pos == 0 || int'(pos) > elems + 1) begin
                    r.status = sll_pkg::ST_RANGE;
                end else if (free_slot == 0) begin
                    r.status = sll_pkg::ST_FULL;
                end else begin
                    pred            = pred_of(int'(pos));
                    s               = free_slot;
                    free_slot       = slot_next[s];
                    slot_data[s]    = val;
                    slot_next[s]    = slot_next[pred];
                    slot_next[pred] = LINK_W'(s);
                    elems++;
                end
            end else begin
                if (pos == 0 || int'(pos) > elems) begin
                    r.status = sll_pkg::ST_RANGE;
                end else begin
                    pred            = pred_of(int'(pos));
                    s               = slot_next[pred];
                    r.removed       = slot_data[s];
                    slot_next[pred] = slot_next[s];
                    slot_next[s]    = free_slot;
                    free_slot       = LINK_W'(s);
                    elems--;
                end
            end
            r.length = sll_pkg::LEN_OUT_W'(elems);
            awaited.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("mismatch %0d: %s", mismatches, msg);
        endtask

        task check_reply(logic [sll_pkg::ST_W-1:0] st, logic [sll_pkg::VAL_W-1:0] rv,
                         logic [sll_pkg::LEN_OUT_W-1:0] ln);
            t_list_reply want;
            replies++;
            if (awaited.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing pending", replies));
            end else begin
                want = awaited.pop_front();
                if (st !== want.status)
                    flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                            replies, st, want.status));
                if (rv !== want.removed)
                    flag_mismatch($sformatf("result %0d removed %h, want %h",
                                            replies, rv, want.removed));
                if (ln !== want.length)
                    flag_mismatch($sformatf("result %0d length %0d, want %0d",
                                            replies, ln, want.length));
            end
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // position[6:0], insert_value[38:7], zero[39]
    logic [0:0]  i_s_axis_tuser  = '0;   // op[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // removed_value[31:0], length[38:32], zero[39]
    logic [1:0]  o_m_axis_tuser;         // status[1:0]

    t_list_mirror mirror = new();

    int src_idle_pct  = 27;
    int sink_idle_pct = 84;
    bit hold_armed    = 1'b0;
    bit filling       = 1'b1;
    int full_hits     = 0;

    static_linked_list_engine_core #(.SLOTS(SLOTS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** static_linked_list_engine_core: FAILED **");
        $finish;
    end

    // output side: check, then drive tready (long hold-off once armed)
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                mirror.check_reply(o_m_axis_tuser, o_m_axis_tdata[31:0],
                                   o_m_axis_tdata[38:32]);
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task send_item(logic op, logic [sll_pkg::POS_W-1:0] pos,
                   logic [sll_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, val, pos};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        mirror.take_request(op, pos, val);
    endtask

    task send_directed();
        send_item(sll_pkg::OP_DELETE, 7'd1,   32'h1234_5678);   // delete from empty list
        send_item(sll_pkg::OP_INSERT, 7'd0,   32'h0BAD_0001);
        send_item(sll_pkg::OP_INSERT, 7'd2,   32'h0BAD_0002);
        send_item(sll_pkg::OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_item(sll_pkg::OP_INSERT, 7'd2,   32'h8000_0000);   // append
        send_item(sll_pkg::OP_INSERT, 7'd1,   32'h0000_0000);   // front
        send_item(sll_pkg::OP_INSERT, 7'd2,   32'hFFFF_FFFF);   // middle
        send_item(sll_pkg::OP_INSERT, 7'd127, 32'h5555_5555);
        send_item(sll_pkg::OP_DELETE, 7'd0,   32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd5,   32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd4,   32'hFFFF_FFFF);   // last
        send_item(sll_pkg::OP_DELETE, 7'd1,   32'h0);           // first
        send_item(sll_pkg::OP_INSERT, 7'd3,   32'hAAAA_AAAA);
        send_item(sll_pkg::OP_DELETE, 7'd2,   32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd127, 32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd1,   32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd1,   32'h0);
        send_item(sll_pkg::OP_DELETE, 7'd1,   32'h0);           // delete from empty list again
    endtask

    // mostly well-formed fill and drain traffic, some noise
    task send_random_item();
        int len;
        logic do_insert;
        len = mirror.elems;
        if (filling && full_hits >= 4) begin
            filling   = 1'b0;
            full_hits = 0;
        end else if (!filling && len == 0) begin
            filling = 1'b1;
        end
        if ($urandom_range(99) < 10) begin
            send_item(1'($urandom_range(1)), 7'($urandom_range(127)), $urandom);
        end else begin
            do_insert = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
            if (len == 0) do_insert = 1'b1;
            if (do_insert) begin
                if (len == MAX_LEN) full_hits++;
                send_item(sll_pkg::OP_INSERT, 7'($urandom_range(len + 1, 1)), $urandom);
            end else begin
                send_item(sll_pkg::OP_DELETE, 7'($urandom_range(len, 1)), $urandom);
            end
        end
    endtask

    initial begin
        int w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_directed();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 84;
                end
                1: begin
                    src_idle_pct  = 84;
                    sink_idle_pct = 27;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_armed    = 1'b1;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS; n++) send_random_item();
        end
        i_s_axis_tvalid <= 1'b0;
        w = 0;
        while (mirror.awaited.size() != 0 && w < DRAIN_WAIT) begin
            @(posedge i_clk);
            w++;
        end
        repeat (200) @(posedge i_clk);
        if (mirror.awaited.size() != 0)
            mirror.flag_mismatch($sformatf("%0d results never arrived",
                                           mirror.awaited.size()));
        if (mirror.mismatches == 0) begin
            $display("** static_linked_list_engine_core: PASSED **");
        end else begin
            $display("** static_linked_list_engine_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sll_pkg.sv
design/sll_ram.sv
design/static_linked_list_engine_core.sv
tb/static_linked_list_engine_core_test.sv
